// ----- sv/rk4_pkg.sv -----
// shared constants for the rk4 damped oscillator step block
package rk4_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_FREQ     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_POSITION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VELOCITY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT       = 3'd5;

    // register reset values
    localparam logic [31:0] RST_TIME_STEP        = 32'd4294967;
    localparam logic [31:0] RST_ANGULAR_FREQ     = 32'd655360;
    localparam logic [31:0] RST_DAMPING          = 32'd6554;
    localparam logic [31:0] RST_INITIAL_POSITION = 32'd655360;
    localparam logic [31:0] RST_INITIAL_VELOCITY = 32'd0;
    localparam logic [31:0] RST_STEP_LIMIT       = 32'd10000;

    // stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 104;

    // rounding shift applied to a product of the shared multiplier
    typedef enum logic [1:0] {
        SH16,
        SH32,
        SH33
    } t_shift;

endpackage

// ----- sv/rk4_damped_oscillator_step.sv -----
// rk4 damped oscillator step: sequencer around one shared multiplier
//
// Each step transfer (reload = 0) advances position x and velocity v, both signed Q16.16, by
// one classical fourth-order Runge-Kutta step of a = -(w*w*x + 2*k*v) with step dt (unsigned
// Q0.32). Every intermediate value rounds to nearest (ties away from zero) and saturates to
// the signed range of the effective width, DATA_WIDTH clamped to 16..32. A reload transfer
// loads x0 and v0 and clears the step count; once the count reaches step_limit a step transfer
// leaves the state as it is and reports done_res. One result transfer follows every input
// transfer. A step shares one 36x32 multiplier, used once a cycle (w*w, two products per stage
// evaluation, two per half step, two per weighted sum), and the two divides by six run one
// byte per cycle; reload and held steps go straight to the result. The input side stays not
// ready until the result transfer completes, so a new item can be taken in the cycle after
// that. Configuration writes are taken at any time, should only be issued while idle, and act
// from the next item on; x0 and v0 reach the state on reload only.
module rk4_damped_oscillator_step #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [rk4_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // [0] reload, rest zero
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] position, [63:32] velocity, [95:64] step_count, [96] done_res, rest zero
    output logic [rk4_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rk4_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);

    // effective saturation width
    localparam int EW = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
    localparam logic signed [39:0] SMAX = 40'((64'sd1 <<< (EW - 1)) - 64'sd1);
    localparam logic signed [39:0] SMIN = -SMAX - 40'sd1;
    localparam logic [48:0]        MMAX = 49'((64'd1 << (EW - 1)) - 64'd1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WSQ,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_FHI,
        S_FLO,
        S_FT,
        S_DIV,
        S_FUPD,
        S_OUT
    } t_state;

    // saturate a signed value to the effective width
    function automatic logic [31:0] sat_w(input logic signed [39:0] v);
        logic [31:0] res;
        if (v > SMAX) begin
            res = SMAX[31:0];
        end else if (v < SMIN) begin
            res = SMIN[31:0];
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // apply sign to a magnitude and saturate
    function automatic logic [31:0] sat_mag(input logic neg, input logic [48:0] m);
        logic [48:0] neg_m;
        logic [31:0] res;
        neg_m = ~m + 49'd1;
        if (neg) begin
            res = (m > MMAX + 49'd1) ? SMIN[31:0] : neg_m[31:0];
        end else begin
            res = (m > MMAX) ? SMAX[31:0] : m[31:0];
        end
        return res;
    endfunction

    // magnitude of a signed word
    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // configuration registers
    logic [31:0] r_dt;
    logic [31:0] r_freq;
    logic [31:0] r_damp;
    logic [31:0] r_x0;
    logic [31:0] r_v0;
    logic [31:0] r_limit;

    // architectural state
    logic [31:0] r_x;
    logic [31:0] r_v;
    logic [31:0] r_cnt;

    // sequencer and datapath
    t_state          r_state;
    logic [1:0]      r_stage;
    logic            r_fsel;      // 0 position update, 1 velocity update
    logic [2:0]      r_dcnt;
    logic [67:0]     r_prod;
    logic            r_neg;
    rk4_pkg::t_shift r_shift;
    logic [31:0]     r_wsq;
    logic [31:0]     r_twok;
    logic [31:0]     r_xs;
    logic [31:0]     r_vs;
    logic [31:0]     r_a;
    logic [31:0]     r_t1;
    logic signed [35:0] r_sx;
    logic signed [35:0] r_sv;
    logic [51:0]     r_hi;
    logic [39:0]     r_div;
    logic [39:0]     r_quo;
    logic [2:0]      r_rem;

    logic [35:0]     w_ma;
    logic [31:0]     w_mb;
    logic [64:0]     w_rsum;
    logic [48:0]     w_mag;
    logic [31:0]     w_fx;
    logic [31:0]     w_acc_new;
    logic [1:0]      w_wt;
    logic signed [35:0] w_acc;
    logic [35:0]     w_acc_mag;
    logic [52:0]     w_tsum;
    logic [10:0]     w_dx;
    logic [20:0]     w_dq_full;
    logic [7:0]      w_dq;
    logic [10:0]     w_drem;
    logic [31:0]     w_six;
    logic [31:0]     w_fin;
    logic [48:0]     w_wsq_c;
    logic [32:0]     w_twok_raw;
    logic            w_in_xfer;

    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // stage weight in the rk4 sum: 1, 2, 2, 1 (as a shift)
    assign w_wt = (r_stage == 2'd0 || r_stage == 2'd3) ? 2'd0 : 2'd1;

    // weighted sum under final update
    assign w_acc     = r_fsel ? r_sv : r_sx;
    assign w_acc_mag = w_acc[35] ? 36'(-w_acc) : 36'(w_acc);

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_IDLE: begin
                w_ma = 36'(r_freq);
                w_mb = r_freq;
            end
            S_M1: begin
                w_ma = 36'(mag32(r_xs));
                w_mb = r_wsq;
            end
            S_M2: begin
                w_ma = 36'(mag32(r_vs));
                w_mb = r_twok;
            end
            S_M3: begin
                w_ma = 36'(mag32(r_vs));
                w_mb = r_dt;
            end
            S_M4: begin
                w_ma = 36'(mag32(r_a));
                w_mb = r_dt;
            end
            S_FHI: begin
                w_ma = w_acc_mag;
                w_mb = 32'(r_dt[31:16]);
            end
            S_FLO: begin
                w_ma = w_acc_mag;
                w_mb = 32'(r_dt[15:0]);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // round the last product to nearest at the chosen shift
    always_comb begin
        w_rsum = '0;
        w_mag  = '0;
        unique case (r_shift)
            rk4_pkg::SH16: begin
                w_rsum = {1'b0, r_prod[63:0]} + (65'd1 << 15);
                w_mag  = w_rsum[64:16];
            end
            rk4_pkg::SH32: begin
                w_rsum = {1'b0, r_prod[63:0]} + (65'd1 << 31);
                w_mag  = 49'(w_rsum[64:32]);
            end
            rk4_pkg::SH33: begin
                w_rsum = {1'b0, r_prod[63:0]} + (65'd1 << 32);
                w_mag  = 49'(w_rsum[64:33]);
            end
            default: begin
                w_rsum = '0;
                w_mag  = '0;
            end
        endcase
    end

    assign w_fx = sat_mag(r_neg, w_mag);

    // acceleration from the two stage products
    assign w_acc_new = sat_w(-(40'($signed(r_t1)) + 40'($signed(w_fx))));

    // coefficients, saturated to the positive end
    assign w_wsq_c    = (w_mag > MMAX) ? MMAX : w_mag;
    assign w_twok_raw = {r_damp, 1'b0};

    // sum * dt / 2^32 before the divide by six
    assign w_tsum = 53'(r_hi) + 53'(r_prod[51:16]) + (53'd3 << 16);

    // divide by six, one byte a step: quotient digit by reciprocal (exact below 1536)
    assign w_dx      = {r_rem, r_div[39:32]};
    assign w_dq_full = 21'(w_dx) * 21'd683;
    assign w_dq      = w_dq_full[19:12];
    assign w_drem    = w_dx - 11'(w_dq) * 11'd6;

    assign w_six = sat_mag(w_acc[35], 49'(r_quo));
    assign w_fin = sat_w(40'($signed(r_fsel ? r_v : r_x)) + 40'($signed(w_six)));

    always_ff @(posedge i_clk) begin
        // payload registers
        r_prod <= 68'(w_ma) * 68'(w_mb);

        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= '0;
            r_fsel  <= 1'b0;
            r_dcnt  <= '0;
            r_neg   <= 1'b0;
            r_shift <= rk4_pkg::SH16;
            r_dt    <= rk4_pkg::RST_TIME_STEP;
            r_freq  <= rk4_pkg::RST_ANGULAR_FREQ;
            r_damp  <= rk4_pkg::RST_DAMPING;
            r_x0    <= rk4_pkg::RST_INITIAL_POSITION;
            r_v0    <= rk4_pkg::RST_INITIAL_VELOCITY;
            r_limit <= rk4_pkg::RST_STEP_LIMIT;
            r_x     <= sat_w(40'($signed(rk4_pkg::RST_INITIAL_POSITION)));
            r_v     <= sat_w(40'($signed(rk4_pkg::RST_INITIAL_VELOCITY)));
            r_cnt   <= '0;
        end else begin
            // configuration write transfer
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rk4_pkg::CFG_TIME_STEP:        r_dt    <= i_cfg_data;
                    rk4_pkg::CFG_ANGULAR_FREQ:     r_freq  <= i_cfg_data;
                    rk4_pkg::CFG_DAMPING:          r_damp  <= i_cfg_data;
                    rk4_pkg::CFG_INITIAL_POSITION: r_x0    <= i_cfg_data;
                    rk4_pkg::CFG_INITIAL_VELOCITY: r_v0    <= i_cfg_data;
                    rk4_pkg::CFG_STEP_LIMIT:       r_limit <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    // w*w is issued here every cycle; used only when a step starts
                    r_shift <= rk4_pkg::SH16;
                    r_neg   <= 1'b0;
                    if (w_in_xfer) begin
                        priority if (i_s_axis_tdata[0]) begin
                            r_x     <= sat_w(40'($signed(r_x0)));
                            r_v     <= sat_w(40'($signed(r_v0)));
                            r_cnt   <= '0;
                            r_state <= S_OUT;
                        end else if (r_cnt < r_limit) begin
                            r_state <= S_WSQ;
                        end else begin
                            // limit reached: hold state
                            r_state <= S_OUT;
                        end
                    end
                end
                S_WSQ: begin
                    r_wsq   <= w_wsq_c[31:0];
                    r_twok  <= (33'(MMAX) < w_twok_raw) ? MMAX[31:0] : w_twok_raw[31:0];
                    r_xs    <= r_x;
                    r_vs    <= r_v;
                    r_sx    <= '0;
                    r_sv    <= '0;
                    r_stage <= '0;
                    r_fsel  <= 1'b0;
                    r_state <= S_M1;
                end
                S_M1: begin
                    // issue x*w^2, retire a*dt of the previous half step
                    if (r_stage != 2'd0) begin
                        r_vs <= sat_w(40'($signed(r_v)) + 40'($signed(w_fx)));
                    end
                    r_neg   <= r_xs[31];
                    r_shift <= rk4_pkg::SH16;
                    r_state <= S_M2;
                end
                S_M2: begin
                    // issue v*2k, retire x*w^2
                    r_t1    <= w_fx;
                    r_sx    <= r_sx + (36'($signed(r_vs)) <<< w_wt);
                    r_neg   <= r_vs[31];
                    r_shift <= rk4_pkg::SH16;
                    r_state <= S_M3;
                end
                S_M3: begin
                    // stage acceleration; issue v*dt unless this was the last stage
                    r_a     <= w_acc_new;
                    r_sv    <= r_sv + (36'($signed(w_acc_new)) <<< w_wt);
                    r_neg   <= r_vs[31];
                    r_shift <= (r_stage == 2'd2) ? rk4_pkg::SH32 : rk4_pkg::SH33;
                    r_state <= (r_stage == 2'd3) ? S_FHI : S_M4;
                end
                S_M4: begin
                    // issue a*dt, retire v*dt into the next stage position
                    r_xs    <= sat_w(40'($signed(r_x)) + 40'($signed(w_fx)));
                    r_neg   <= r_a[31];
                    r_stage <= r_stage + 2'd1;
                    r_state <= S_M1;
                end
                S_FHI: begin
                    r_state <= S_FLO;
                end
                S_FLO: begin
                    r_hi    <= r_prod[51:0];
                    r_state <= S_FT;
                end
                S_FT: begin
                    r_div   <= 40'(w_tsum[52:16]);
                    r_quo   <= '0;
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_div  <= r_div << 8;
                    r_quo  <= {r_quo[31:0], w_dq};
                    r_rem  <= w_drem[2:0];
                    r_dcnt <= r_dcnt + 3'd1;
                    if (r_dcnt == 3'd4) begin
                        r_state <= S_FUPD;
                    end
                end
                S_FUPD: begin
                    if (r_fsel) begin
                        r_v     <= w_fin;
                        r_cnt   <= r_cnt + 32'd1;
                        r_state <= S_OUT;
                    end else begin
                        r_x     <= w_fin;
                        r_fsel  <= 1'b1;
                        r_state <= S_FHI;
                    end
                end
                S_OUT: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {7'd0, (r_cnt >= r_limit), r_cnt, r_v, r_x};

    // busy right after an input transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_s_axis_tready)
        else $error("input accepted again while an item is in flight");

    // never ready for input while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while result pending");

    // ready again once the result transfer completes
    a_ready_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready) |=> o_s_axis_tready)
        else $error("not ready after result transfer");

    // step count only advances by one or clears
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && $past(i_rst_n) && (r_cnt != $past(r_cnt))) |->
            ((r_cnt == $past(r_cnt) + 32'd1) || (r_cnt == 32'd0)))
        else $error("step count jumped");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// testbench for the rk4 damped oscillator step block: directed table, then random runs
module testbench;

    localparam int IDX_W  = rk4_pkg::CFG_IDX_W;
    localparam int IN_W   = rk4_pkg::IN_TDATA_W;
    localparam int OUT_W  = rk4_pkg::OUT_TDATA_W;

    // input operations
    localparam logic OP_STEP   = 1'b0;
    localparam logic OP_RELOAD = 1'b1;

    // indexes past the register list, writes must have no effect
    localparam logic [IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // saturation range of signed Q16.16
    localparam longint      Q_HI   = 64'sd2147483647;
    localparam longint      Q_LO   = -64'sd2147483648;
    localparam logic [63:0] Q_HI_U = 64'h0000_0000_7FFF_FFFF;

    localparam int DIR_ROWS   = 41;
    localparam int PHASES     = 4;
    localparam int PHASE_ITEMS = 215;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] velocity;
        logic [31:0] step_count;
        logic        done_res;
    } t_osc_result;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [IDX_W-1:0]      idx;
        logic [31:0]           data;
        logic                  op;
        logic                  typed;
        t_osc_result           want;
    } t_dir_row;

    localparam t_osc_result NO_WANT = '0;
    localparam t_osc_result RST_LOADED =
        '{rk4_pkg::RST_INITIAL_POSITION, rk4_pkg::RST_INITIAL_VELOCITY, 32'd0, 1'b0};
    localparam t_osc_result RST_LOADED_DONE =
        '{rk4_pkg::RST_INITIAL_POSITION, rk4_pkg::RST_INITIAL_VELOCITY, 32'd0, 1'b1};

    // directed stimulus; typed expectations only where obvious
    t_dir_row dir_tab [DIR_ROWS] = '{
        '{ROW_ITEM, '0, '0, OP_RELOAD, 1'b1, RST_LOADED},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_RELOAD, 1'b1, RST_LOADED},
        '{ROW_CFG, CFG_SPARE_6, 32'hFFFF_FFFF, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_SPARE_7, 32'hFFFF_FFFF, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT},
        // zero limit: done right after reload, steps hold
        '{ROW_CFG, rk4_pkg::CFG_STEP_LIMIT, 32'd0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_RELOAD, 1'b1, RST_LOADED_DONE},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b1, RST_LOADED_DONE},
        // limit reached after two steps
        '{ROW_CFG, rk4_pkg::CFG_STEP_LIMIT, 32'd2, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_RELOAD, 1'b1, RST_LOADED},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT},
        // upper extremes everywhere
        '{ROW_CFG, rk4_pkg::CFG_TIME_STEP, 32'hFFFF_FFFF, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_ANGULAR_FREQ, 32'hFFFF_FFFF, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_DAMPING, 32'hFFFF_FFFF, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_INITIAL_POSITION, 32'h7FFF_FFFF, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_INITIAL_VELOCITY, 32'h8000_0000, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_STEP_LIMIT, 32'hFFFF_FFFF, OP_STEP, 1'b0, NO_WANT},
        // new x0 and v0 are not in the state until reload
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_RELOAD, 1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0}},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT},
        // lower extremes, zero dt leaves the state alone
        '{ROW_CFG, rk4_pkg::CFG_TIME_STEP, 32'd0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_ANGULAR_FREQ, 32'd0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_DAMPING, 32'd0, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_INITIAL_POSITION, 32'h8000_0000, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_INITIAL_VELOCITY, 32'h7FFF_FFFF, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_RELOAD, 1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b0}},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 1'b0}},
        // back to reset settings
        '{ROW_CFG, rk4_pkg::CFG_TIME_STEP, rk4_pkg::RST_TIME_STEP, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_ANGULAR_FREQ, rk4_pkg::RST_ANGULAR_FREQ, OP_STEP, 1'b0,
          NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_DAMPING, rk4_pkg::RST_DAMPING, OP_STEP, 1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_INITIAL_POSITION, rk4_pkg::RST_INITIAL_POSITION, OP_STEP,
          1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_INITIAL_VELOCITY, rk4_pkg::RST_INITIAL_VELOCITY, OP_STEP,
          1'b0, NO_WANT},
        '{ROW_CFG, rk4_pkg::CFG_STEP_LIMIT, rk4_pkg::RST_STEP_LIMIT, OP_STEP, 1'b0, NO_WANT},
        '{ROW_ITEM, '0, '0, OP_RELOAD, 1'b1, RST_LOADED},
        '{ROW_ITEM, '0, '0, OP_STEP, 1'b0, NO_WANT}
    };

    // idling per random phase: none, sender, receiver, both
    int unsigned send_pcts [PHASES] = '{0, 57, 0, 19};
    int unsigned rcv_pcts  [PHASES] = '{0, 0, 57, 19};

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_W-1:0]        i_s_axis_tdata  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]       o_m_axis_tdata;
    logic                   i_cfg_valid     = 1'b0;
    logic                   o_cfg_ready;
    logic [IDX_W-1:0]       i_cfg_index     = '0;
    logic [31:0]            i_cfg_data      = '0;

    // predictor copy of the registers and state
    logic [31:0] osc_dt    = rk4_pkg::RST_TIME_STEP;
    logic [31:0] osc_w     = rk4_pkg::RST_ANGULAR_FREQ;
    logic [31:0] osc_k     = rk4_pkg::RST_DAMPING;
    logic [31:0] osc_x0    = rk4_pkg::RST_INITIAL_POSITION;
    logic [31:0] osc_v0    = rk4_pkg::RST_INITIAL_VELOCITY;
    logic [31:0] osc_limit = rk4_pkg::RST_STEP_LIMIT;
    longint      osc_pos   = longint'(signed'(rk4_pkg::RST_INITIAL_POSITION));
    longint      osc_vel   = longint'(signed'(rk4_pkg::RST_INITIAL_VELOCITY));
    logic [31:0] osc_cnt   = '0;

    t_osc_result osc_expected [$];
    t_osc_result seen_res;
    t_osc_result want_res;
    int          mismatch_cnt  = 0;
    int unsigned send_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;

    rk4_damped_oscillator_step #(
        .DATA_WIDTH(32)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    function automatic logic [63:0] mag(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // signed a times unsigned b, shifted by sh, magnitude rounded half away from zero
    function automatic longint round_mul(input longint a, input logic [63:0] b,
                                         input int unsigned sh);
        logic [63:0] r;
        r = (mag(a) * b + (64'd1 << (sh - 1))) >> sh;
        if (r > 64'h0000_7FFF_FFFF_FFFF) r = 64'h0000_7FFF_FFFF_FFFF;
        return clamp_q((a < 0) ? -longint'(r) : longint'(r));
    endfunction

    function automatic longint accel_of(input longint x, input longint v,
                                        input logic [63:0] wsq, input logic [63:0] twok);
        return clamp_q(-(round_mul(x, wsq, 16) + round_mul(v, twok, 16)));
    endfunction

    // round(sum * dt / (6 * 2^32)) with the low product bits folded in first
    function automatic longint dt_sixth(input longint sum, input logic [63:0] dt);
        logic [63:0] m;
        logic [63:0] p;
        m = mag(sum);
        p = m * (dt >> 16) + ((m * (dt & 64'hFFFF)) >> 16);
        p = (p + (64'd3 << 16)) / (64'd6 << 16);
        return clamp_q((sum < 0) ? -longint'(p) : longint'(p));
    endfunction

    // applies one item to the predicted state and returns the result it causes
    function automatic t_osc_result advance_oscillator(input logic op);
        logic [63:0] dt;
        logic [63:0] wsq;
        logic [63:0] twok;
        longint      x, v, x2, v2, x3, v3, x4, v4;
        longint      a1, a2, a3, a4;
        t_osc_result res;
        if (op == OP_RELOAD) begin
            osc_pos = clamp_q(longint'(signed'(osc_x0)));
            osc_vel = clamp_q(longint'(signed'(osc_v0)));
            osc_cnt = '0;
        end else if (osc_cnt < osc_limit) begin
            dt   = 64'(osc_dt);
            wsq  = (64'(osc_w) * 64'(osc_w) + 64'd32768) >> 16;
            twok = 64'(osc_k) * 64'd2;
            if (wsq > Q_HI_U) wsq = Q_HI_U;
            if (twok > Q_HI_U) twok = Q_HI_U;
            x  = osc_pos;
            v  = osc_vel;
            a1 = accel_of(x, v, wsq, twok);
            x2 = clamp_q(x + round_mul(v, dt, 33));
            v2 = clamp_q(v + round_mul(a1, dt, 33));
            a2 = accel_of(x2, v2, wsq, twok);
            x3 = clamp_q(x + round_mul(v2, dt, 33));
            v3 = clamp_q(v + round_mul(a2, dt, 33));
            a3 = accel_of(x3, v3, wsq, twok);
            x4 = clamp_q(x + round_mul(v3, dt, 32));
            v4 = clamp_q(v + round_mul(a3, dt, 32));
            a4 = accel_of(x4, v4, wsq, twok);
            osc_pos = clamp_q(x + dt_sixth(v + 2 * v2 + 2 * v3 + v4, dt));
            osc_vel = clamp_q(v + dt_sixth(a1 + 2 * a2 + 2 * a3 + a4, dt));
            osc_cnt = osc_cnt + 32'd1;
        end
        res.position   = osc_pos[31:0];
        res.velocity   = osc_vel[31:0];
        res.step_count = osc_cnt;
        res.done_res   = (osc_cnt >= osc_limit);
        return res;
    endfunction

    // random register value, extremes mixed in with useful ranges
    function automatic logic [31:0] pick_reg(input logic [IDX_W-1:0] idx);
        int unsigned sel;
        logic        is_signed;
        sel       = $urandom_range(0, 9);
        is_signed = (idx == rk4_pkg::CFG_INITIAL_POSITION) ||
                    (idx == rk4_pkg::CFG_INITIAL_VELOCITY);
        if (sel == 0) return is_signed ? 32'h8000_0000 : 32'd0;
        if (sel == 1) return is_signed ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
        if (sel == 2) return $urandom;
        case (idx)
            rk4_pkg::CFG_TIME_STEP:    return $urandom_range(1, 32'h0100_0000);
            rk4_pkg::CFG_ANGULAR_FREQ: return $urandom_range(0, 32'h0014_0000);
            rk4_pkg::CFG_DAMPING:      return $urandom_range(0, 32'h0002_0000);
            rk4_pkg::CFG_STEP_LIMIT:   return $urandom_range(0, 40);
            default:          return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    // holds the stream idle until every pending result has come back
    task automatic wait_drained;
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (osc_expected.size() != 0);
    endtask

    // leaves i_cfg_valid high so back-to-back writes need no toggle
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rk4_pkg::CFG_TIME_STEP:        osc_dt    = val;
            rk4_pkg::CFG_ANGULAR_FREQ:     osc_w     = val;
            rk4_pkg::CFG_DAMPING:          osc_k     = val;
            rk4_pkg::CFG_INITIAL_POSITION: osc_x0    = val;
            rk4_pkg::CFG_INITIAL_VELOCITY: osc_v0    = val;
            rk4_pkg::CFG_STEP_LIMIT:       osc_limit = val;
            default:              ;
        endcase
    endtask

    // one input transfer; valid stays high afterward unless the next call idles first
    task automatic send_item(input logic op, input logic use_typed,
                             input t_osc_result typed_res);
        t_osc_result pred;
        i_cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_W - 1){1'b0}}, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = advance_oscillator(op);
        osc_expected = {osc_expected, (use_typed ? typed_res : pred)};
    endtask

    // result side: random back-pressure and field checks
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_res.position   = o_m_axis_tdata[31:0];
            seen_res.velocity   = o_m_axis_tdata[63:32];
            seen_res.step_count = o_m_axis_tdata[95:64];
            seen_res.done_res   = o_m_axis_tdata[96];
            if (osc_expected.size() == 0) begin
                $error("result transfer with nothing pending: %h", o_m_axis_tdata);
                mismatch_cnt++;
            end else begin
                want_res = osc_expected.pop_front();
                if (seen_res.position !== want_res.position) begin
                    $error("position: expected %0d, got %0d",
                           $signed(want_res.position), $signed(seen_res.position));
                    mismatch_cnt++;
                end
                if (seen_res.velocity !== want_res.velocity) begin
                    $error("velocity: expected %0d, got %0d",
                           $signed(want_res.velocity), $signed(seen_res.velocity));
                    mismatch_cnt++;
                end
                if (seen_res.step_count !== want_res.step_count) begin
                    $error("step_count: expected %0d, got %0d",
                           want_res.step_count, seen_res.step_count);
                    mismatch_cnt++;
                end
                if (seen_res.done_res !== want_res.done_res) begin
                    $error("done_res: expected %0b, got %0b",
                           want_res.done_res, seen_res.done_res);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        int phase_items;
        int seg_len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_item(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // random runs: new settings, reload, then a stream of steps with stray reloads
        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct = send_pcts[ph];
            rcv_stall_pct = rcv_pcts[ph];
            phase_items   = 0;
            while (phase_items < PHASE_ITEMS) begin
                wait_drained();
                for (int r = rk4_pkg::CFG_TIME_STEP; r <= rk4_pkg::CFG_STEP_LIMIT; r++) begin
                    if ($urandom_range(0, 9) < 7)
                        write_reg(IDX_W'(r), pick_reg(IDX_W'(r)));
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_item(OP_RELOAD, 1'b0, NO_WANT);
                    phase_items++;
                end
                seg_len = $urandom_range(10, 50);
                repeat (seg_len) begin
                    send_item(($urandom_range(0, 19) == 0) ? OP_RELOAD : OP_STEP,
                              1'b0, NO_WANT);
                    phase_items++;
                end
            end
        end

        wait_drained();
        // room for any stray extra result
        repeat (100) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
